/* rtl/core/row_change_dictionary_encoder_top_defines.svh */
// ----------------------------------------------------------------------------
// Row change dictionary encoder: assertion macros
// Concurrent check macros, empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ROW_CHANGE_DICTIONARY_ENCODER_TOP_DEFINES_SVH
`define ROW_CHANGE_DICTIONARY_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RCDE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
`define RCDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`else
`define RCDE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RCDE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/rcde_pkg.sv */
// ----------------------------------------------------------------------------
// Row change dictionary encoder package
// Result kinds, controller states and the control group of a dictionary cell.
// ----------------------------------------------------------------------------
package rcde_pkg;

	localparam int KIND_W      = 2;
	localparam int VALUE_W     = 8;
	localparam int OUT_COUNT_W = 9;
	localparam int FLAG_W      = 8;
	localparam int FLAG_POS_W  = 3;

	localparam logic [KIND_W-1:0] KIND_INDEX    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FLAGS    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;

	localparam logic [FLAG_POS_W-1:0] FLAG_LAST_POS = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_SCAN,
		ST_EMIT_IDX,
		ST_EMIT_FLAG
	} state_t;

	typedef struct packed {
		logic compare;
		logic shift;
		logic write;
	} cell_ctl_t;

endpackage

/* rtl/core/rcde_cell.sv */
// ----------------------------------------------------------------------------
// Dictionary cell
// Holds one stored row, compares it with the search key and passes its hit
// bit toward the head of the chain.
// ----------------------------------------------------------------------------
module rcde_cell #(
	parameter int ROW_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rcde_pkg::cell_ctl_t ctl,
	input  logic                occupied,
	input  logic                write_sel,
	input  logic [ROW_BITS-1:0] key,
	input  logic                hit_in,
	output logic                hit_out
);
	import rcde_pkg::*;

	logic [ROW_BITS-1:0] entry_q;
	logic                hit_q;

	always_ff @(posedge clk) begin
		if (ctl.write && write_sel) begin
			entry_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.compare) begin
			hit_q <= occupied && (entry_q == key);
		end else if (ctl.shift) begin
			hit_q <= hit_in;
		end
	end

	assign hit_out = hit_q;

endmodule

/* rtl/core/rcde_chain.sv */
// ----------------------------------------------------------------------------
// Dictionary cell chain
// Row of cells; hit bits advance one cell toward the head on each shift.
// ----------------------------------------------------------------------------
module rcde_chain #(
	parameter int DICT_DEPTH = 256,
	parameter int ROW_BITS   = 16,
	parameter int CNT_W      = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rcde_pkg::cell_ctl_t ctl,
	input  logic [CNT_W-1:0]    count,
	input  logic [ROW_BITS-1:0] key,
	output logic                head_hit
);
	import rcde_pkg::*;

	logic [DICT_DEPTH:0] hit_link;

	assign hit_link[DICT_DEPTH] = 1'b0;

	for (genvar i = 0; i < DICT_DEPTH; i++) begin : g_cell
		rcde_cell #(
			.ROW_BITS(ROW_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.occupied (CNT_W'(i) < count),
			.write_sel(CNT_W'(i) == count),
			.key      (key),
			.hit_in   (hit_link[i+1]),
			.hit_out  (hit_link[i])
		);
	end

	assign head_hit = hit_link[0];

endmodule

/* rtl/core/row_change_dictionary_encoder_top.sv */
// ----------------------------------------------------------------------------
// Row change dictionary encoder
// Flags changed glyph rows, indexes changed rows in a dictionary of unique
// rows and emits the packed change flag byte after every eighth row.
// ----------------------------------------------------------------------------
// channel   | direction | handshake            | payload
// s_axis    | in        | tvalid/tready        | tdata: row_pixels
// m_axis    | out       | tvalid/tready/tlast  | tuser: result_kind; tdata: value, count
//
// An unchanged row is accepted in the idle state and then emits a flag byte when one is due.
// A changed row passes through the compare, scan and index emit states, and then through
// the flag emit state when a flag byte follows; in the scan state
// the hit bits of all cells are shifted toward the head of the cell chain
// one cell per cycle until the match or the end of the stored rows.
// Reset clears control state only; stored rows are valid below the fill count.
// A full output register stalls the controller before loading each result.
// ----------------------------------------------------------------------------
`include "row_change_dictionary_encoder_top_defines.svh"

module row_change_dictionary_encoder_top #(
	parameter int DICT_DEPTH = 256,
	parameter int ROW_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [ROW_BITS-1:0] row_pixels, rest zero padding
	input  logic [((ROW_BITS+7)/8)*8-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] result_value, [16:8] unique_count, [23:17] zero
	output logic [23:0]                       m_axis_tdata,
	// [1:0] result_kind
	output logic [rcde_pkg::KIND_W-1:0]       m_axis_tuser,
	output logic                              m_axis_tlast
);
	import rcde_pkg::*;

	localparam int CNT_W = $clog2(DICT_DEPTH + 1);
	localparam int IDX_W = $clog2(DICT_DEPTH);

	state_t state_q, state_d;

	logic [ROW_BITS-1:0]   prev_row_q;
	logic                  have_prev_q;
	logic [FLAG_W-1:0]     flag_shift_q;
	logic [FLAG_POS_W-1:0] flag_pos_q;
	logic                  flag_due_q;
	logic [ROW_BITS-1:0]   key_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      scan_q;
	logic [KIND_W-1:0]     res_kind_q;
	logic [VALUE_W-1:0]    res_value_q;

	logic                  out_valid_q;
	logic [KIND_W-1:0]     out_kind_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic [OUT_COUNT_W-1:0] out_count_q;
	logic                  out_last_q;

	cell_ctl_t             ctl;
	logic                  head_hit;
	logic                  in_accept;
	logic                  changed;
	logic                  can_load;
	logic                  full;
	logic                  scan_last;
	logic                  hit_done;
	logic                  miss_done;
	logic                  load_idx;
	logic                  load_flag;
	logic [ROW_BITS-1:0]   row_in;

	assign row_in    = s_axis_tdata[ROW_BITS-1:0];
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign changed   = !have_prev_q || (row_in != prev_row_q);
	assign can_load  = !out_valid_q || m_axis_tready;
	assign full      = (count_q == CNT_W'(DICT_DEPTH));
	assign scan_last = ((CNT_W'(scan_q) + CNT_W'(1)) >= count_q);

	rcde_chain #(
		.DICT_DEPTH(DICT_DEPTH),
		.ROW_BITS  (ROW_BITS),
		.CNT_W     (CNT_W)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.count   (count_q),
		.key     (key_q),
		.head_hit(head_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctl           = '0;
		hit_done      = 1'b0;
		miss_done     = 1'b0;
		load_idx      = 1'b0;
		load_flag     = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (in_accept) begin
					if (changed) begin
						state_d = ST_COMPARE;
					end else if (flag_pos_q == FLAG_LAST_POS) begin
						state_d = ST_EMIT_FLAG;
					end
				end
			end
			ST_COMPARE: begin
				ctl.compare = 1'b1;
				state_d     = ST_SCAN;
			end
			ST_SCAN: begin
				if (head_hit) begin
					hit_done = 1'b1;
					state_d  = ST_EMIT_IDX;
				end else if (scan_last) begin
					miss_done = 1'b1;
					ctl.write = !full;
					state_d   = ST_EMIT_IDX;
				end else begin
					ctl.shift = 1'b1;
				end
			end
			ST_EMIT_IDX: begin
				if (can_load) begin
					load_idx = 1'b1;
					state_d  = flag_due_q ? ST_EMIT_FLAG : ST_IDLE;
				end
			end
			ST_EMIT_FLAG: begin
				if (can_load) begin
					load_flag = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_row_q   <= '0;
			have_prev_q  <= 1'b0;
			flag_shift_q <= '0;
			flag_pos_q   <= '0;
			flag_due_q   <= 1'b0;
			count_q      <= '0;
			scan_q       <= '0;
		end else begin
			if (in_accept) begin
				if (changed) begin
					prev_row_q  <= row_in;
					have_prev_q <= 1'b1;
				end
				flag_shift_q <= {flag_shift_q[FLAG_W-2:0], changed};
				flag_pos_q   <= flag_pos_q + 1'b1;
				flag_due_q   <= (flag_pos_q == FLAG_LAST_POS);
			end
			if (ctl.compare) begin
				scan_q <= '0;
			end else if (ctl.shift) begin
				scan_q <= scan_q + 1'b1;
			end
			if (ctl.write) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			key_q <= row_in;
		end
		if (hit_done) begin
			res_kind_q  <= KIND_INDEX;
			res_value_q <= VALUE_W'(scan_q);
		end else if (miss_done) begin
			res_kind_q  <= full ? KIND_OVERFLOW : KIND_INDEX;
			res_value_q <= full ? '0 : VALUE_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_idx || load_flag) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_idx) begin
			out_kind_q  <= res_kind_q;
			out_value_q <= res_value_q;
			out_count_q <= OUT_COUNT_W'(count_q);
			out_last_q  <= !flag_due_q;
		end else if (load_flag) begin
			out_kind_q  <= KIND_FLAGS;
			out_value_q <= flag_shift_q;
			out_count_q <= OUT_COUNT_W'(count_q);
			out_last_q  <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_count_q, out_value_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

	`RCDE_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DICT_DEPTH))
	`RCDE_ASSERT_IMPL(a_count_step, clk, arst_n, 1'b1,
		(count_q == $past(count_q)) || (count_q == CNT_W'($past(count_q) + 1'b1)))
	`RCDE_ASSERT_IMPL(a_overflow_full, clk, arst_n,
		out_valid_q && (out_kind_q == KIND_OVERFLOW), count_q == CNT_W'(DICT_DEPTH))
	`RCDE_ASSERT_IMPL(a_flags_last, clk, arst_n,
		out_valid_q && (out_kind_q == KIND_FLAGS), out_last_q)
	`RCDE_ASSERT_NEXT(a_write_leaves_scan, clk, arst_n, ctl.write, state_q == ST_EMIT_IDX)

endmodule
